>>> design/assert_macros.svh
// Assertion helpers shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define RKX_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Condition followed by a consequence in the next cycle.
`define RKX_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> design/rkx_pkg.sv
package rkx_pkg;

    localparam int LENGTH_BITS = 16;

    localparam logic [31:0] ROLL_INIT = 32'h019327c8;
    localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

    localparam logic [7:0] TAIL_0 = 8'ha1;
    localparam logic [7:0] TAIL_1 = 8'h6c;
    localparam logic [7:0] TAIL_2 = 8'h31;
    localparam logic [7:0] TAIL_3 = 8'h97;

    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    // register index, taken from paddr[3]
    localparam logic REG_KEY_LOW = 1'b0;

    typedef struct packed {
        logic       func;
        logic [7:0] data_in;
        logic       last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } out_item_t;

    // front to back: head of the job queue
    typedef struct packed {
        logic       valid;
        logic       dec;
        logic [7:0] data;
        logic       last;
    } job_t;

    function automatic logic [7:0] key_byte(input logic [3:0] pos,
                                            input logic [63:0] key_low,
                                            input logic [31:0] roll);
        logic [7:0] kb;
        kb = 8'h00;
        case (pos) inside
            [4'd0:4'd7]:   kb = key_low[{pos[2:0], 3'b000} +: 8];
            [4'd8:4'd11]:  kb = roll[{pos[1:0], 3'b000} +: 8];
            4'd12:         kb = TAIL_0;
            4'd13:         kb = TAIL_1;
            4'd14:         kb = TAIL_2;
            4'd15:         kb = TAIL_3;
            default:       kb = 8'h00;
        endcase
        return kb;
    endfunction

endpackage

>>> design/rkx_front.sv
module rkx_front import rkx_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item_in,
    output job_t     job,
    input  logic     take
);

    job_t       slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_take;

    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_take = take && (count_reg != 2'd0);

    always_comb
    begin
        wptr_next  = do_push ? ~wptr_reg : wptr_reg;
        rptr_next  = do_take ? ~rptr_reg : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // classify on entry: direction decoded once here
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg].valid <= 1'b1;
            slot_reg[wptr_reg].dec   <= (item_in.func == FUNC_DECRYPT);
            slot_reg[wptr_reg].data  <= item_in.data_in;
            slot_reg[wptr_reg].last  <= item_in.last_in;
        end
    end

    always_comb
    begin
        job       = slot_reg[rptr_reg];
        job.valid = (count_reg != 2'd0);
    end

endmodule

>>> design/rkx_back.sv
module rkx_back import rkx_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  job_t            job,
    output logic            take,
    input  logic [63:0]     key_low,
    input  logic            reload,
    output logic            empty,
    input  logic            pop,
    output out_item_t       result
);

    // per-direction state, indexed by the decrypt flag
    logic [31:0]            roll_reg [2];
    logic [7:0]             prev_reg [2];
    logic [LENGTH_BITS-1:0] cnt_reg  [2];

    out_item_t  res_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    logic [LENGTH_BITS-1:0] cnt_cur, cnt_inc;
    logic [31:0]            roll_cur;
    logic [7:0]             prev_cur, res_byte, cipher;

    assign take   = job.valid && (count_reg != 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign do_pop = pop && !empty;
    assign result = res_reg[rptr_reg];

    always_comb
    begin
        cnt_cur  = cnt_reg[job.dec];
        roll_cur = roll_reg[job.dec];
        prev_cur = prev_reg[job.dec];
        res_byte = job.data ^ key_byte(cnt_cur[3:0], key_low, roll_cur) ^ prev_cur;
        cipher   = job.dec ? job.data : res_byte;
        cnt_inc  = (cnt_cur == CNT_MAX) ? CNT_MAX : cnt_cur + 1'b1;
    end

    always_comb
    begin
        count_next = count_reg;
        if (take && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!take && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                roll_reg[i] <= ROLL_INIT;
                prev_reg[i] <= 8'h00;
                cnt_reg[i]  <= '0;
            end
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                if (job.last)
                begin
                    cnt_reg[job.dec]  <= '0;
                    prev_reg[job.dec] <= 8'h00;
                end
                else
                begin
                    cnt_reg[job.dec]  <= cnt_inc;
                    prev_reg[job.dec] <= cipher;
                end
                wptr_reg <= ~wptr_reg;
            end
            // key write: rolling words only
            if (reload)
            begin
                roll_reg[0] <= ROLL_INIT;
                roll_reg[1] <= ROLL_INIT;
            end
            else if (take && job.last)
            begin
                roll_reg[job.dec] <= roll_cur + 32'(cnt_inc);
            end
            if (do_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg[wptr_reg].data_out <= res_byte;
            res_reg[wptr_reg].last_out <= job.last;
        end
    end

endmodule

>>> design/rolling_key_xor_packet_cipher.sv
// Rolling-key XOR packet cipher, one byte per transaction in each direction.
// Sustains one byte per clock while the result queue has room; the loop is
// the per-direction chaining byte, position count and rolling word, updated
// in the back-end cycle that ciphers a byte. A byte pushed into an idle block
// passes the input queue and then the result register to the result ports.
// Both sides are two-entry queues, so push and pop stall independently. The key
// is written over the APB port with paddr[3] clear (64-bit data); that write
// also reloads both rolling words to 0x019327c8, while any packet in progress
// keeps its position and chaining byte. Write the key only while idle. Every
// packet must carry at least one byte, marked last on its final byte.
module rolling_key_xor_packet_cipher import rkx_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  in_item_t    item_in,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output out_item_t   result,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0] key_low_reg;
    logic        cfg_wr;
    logic        key_wr;
    job_t        job;
    logic        take;

    // APB: zero wait states; register index sits in paddr[3]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign key_wr = cfg_wr && (paddr[3] == REG_KEY_LOW);
    assign prdata = (paddr[3] == REG_KEY_LOW) ? key_low_reg : 64'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg <= 64'h0;
        end
        else if (key_wr)
        begin
            key_low_reg <= pwdata;
        end
    end

    // front: accept and classify each transaction into the job queue
    rkx_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item_in (item_in),
        .job     (job),
        .take    (take)
    );

    // back: keystream, chaining and rolling-word update, result queue
    rkx_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (job),
        .take    (take),
        .key_low (key_low_reg),
        .reload  (key_wr),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

>>> design/rkx_checker.sv
`include "assert_macros.svh"

module rkx_checker import rkx_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input out_item_t   result,
    input logic        psel,
    input logic        penable,
    input logic        pready
);

    // input queue can only back up behind a stalled result queue
    `RKX_ASSERT_IMP(a_full_needs_result, full, !empty, "input full with no result waiting")

    // a byte accepted into an idle result side shows once it has passed the input queue and result registers
    `RKX_ASSERT_IMP(a_latency, push && !full && empty, ##2 !empty, "result late")

    // a waiting result holds until popped
    `RKX_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "result dropped")

    // zero wait state port
    `RKX_ASSERT_IMP(a_ready, psel && penable, pready, "pready low in access")

endmodule

bind rolling_key_xor_packet_cipher rkx_checker u_rkx_checker (.*);
